// ----- hdl/llars_pkg.sv -----
// ----------------------------------------------------------------------------
// llars_pkg
// Shared constants for the life-like automaton row stepper.
// ----------------------------------------------------------------------------
package llars_pkg;

    // Configuration register widths and indexes
    localparam int GRID_W_W   = 7;
    localparam int RULE_W     = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RULE_WORD  = 2'd1;

    localparam logic [GRID_W_W-1:0] GRID_WIDTH_RST = 7'd64;
    localparam logic [RULE_W-1:0]   RULE_WORD_RST  = 18'd6152;

    // Rule word layout: bit (alive * ALIVE_STRIDE + neighbor count)
    localparam int RULE_IDX_W = 5;
    localparam int COUNT_W    = 4;
    localparam logic [RULE_IDX_W-1:0] ALIVE_STRIDE = 5'd9;

    // Result row numbering
    localparam int ROW_IDX_W = 16;
    localparam logic [ROW_IDX_W-1:0] ROW_IDX_MAX = 16'hFFFF;
    localparam logic [ROW_IDX_W-1:0] ROW_IDX_ONE = 16'd1;

endpackage

// ----- hdl/life_like_automaton_row_stepper_top.sv -----
// ----------------------------------------------------------------------------
// life_like_automaton_row_stepper_top
// Streams a grid row by row and returns the next generation of each row.
// ----------------------------------------------------------------------------
// The block takes one row per cycle and writes each result into a four-entry
// result queue as the row that completes it is accepted. A row yields the
// next generation of the row before it; the bottom row (last_row) yields
// that plus its own next generation, so it puts two results in the queue
// unless it is also the top row. in_ready is high while the queue has two
// free entries, so with out_ready held high the input runs at one row per
// cycle; only a stalled output throttles it. All cells of a row are updated
// in parallel, one lane per cell. Registers are written through the cfg
// channel and take effect for rows accepted afterwards.
module life_like_automaton_row_stepper_top
    import llars_pkg::*;
#(
    parameter int MAX_WIDTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input rows
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MAX_WIDTH-1:0]  row_cells,
    input  logic                  last_row,
    // Result rows
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [MAX_WIDTH-1:0]  next_row,
    output logic [ROW_IDX_W-1:0]  row_index,
    output logic                  frame_done
);

    localparam int DATA_W = MAX_WIDTH + ROW_IDX_W + 1;

    logic [GRID_W_W-1:0]  grid_width_reg;
    logic [RULE_W-1:0]    rule_word_reg;
    logic [MAX_WIDTH-1:0] row_above_reg;
    logic [MAX_WIDTH-1:0] row_above_next;
    logic [MAX_WIDTH-1:0] row_middle_reg;
    logic [MAX_WIDTH-1:0] row_middle_next;
    logic                 held_reg;
    logic                 held_next;
    logic [ROW_IDX_W-1:0] row_count_reg;
    logic [ROW_IDX_W-1:0] row_count_next;
    logic [ROW_IDX_W-1:0] row_count_inc;

    logic                 in_xfer;
    logic [MAX_WIDTH-1:0] used_mask;
    logic [MAX_WIDTH-1:0] flush_up;
    logic [MAX_WIDTH-1:0] gen_prev;
    logic [MAX_WIDTH-1:0] gen_flush;
    logic                 push_a;
    logic                 push_b;
    logic [DATA_W-1:0]    data_a;
    logic [DATA_W-1:0]    data_b;
    logic [DATA_W-1:0]    out_data;
    logic                 space_two;
    logic [2:0]           q_level;

    assign cfg_ready = 1'b1;
    assign in_ready  = space_two;
    assign in_xfer   = in_valid && in_ready;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= GRID_WIDTH_RST;
            rule_word_reg  <= RULE_WORD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GRID_WIDTH: grid_width_reg <= cfg_data[GRID_W_W-1:0];
                REG_RULE_WORD:  rule_word_reg  <= cfg_data[RULE_W-1:0];
                default:        ;
            endcase
        end
    end

    // Cells at or past the grid width are dead
    for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_mask
        assign used_mask[i] = (grid_width_reg > GRID_W_W'(i));
    end

    // Result for the row before the incoming one
    llars_gen #(.WIDTH(MAX_WIDTH)) u_gen_prev (
        .up        (row_above_reg),
        .mid       (row_middle_reg),
        .down      (row_cells),
        .used_mask (used_mask),
        .rule_word (rule_word_reg),
        .next_row  (gen_prev)
    );

    // Result for the bottom row itself, dead row below
    assign flush_up = held_reg ? row_middle_reg : '0;

    llars_gen #(.WIDTH(MAX_WIDTH)) u_gen_flush (
        .up        (flush_up),
        .mid       (row_cells),
        .down      ('0),
        .used_mask (used_mask),
        .rule_word (rule_word_reg),
        .next_row  (gen_flush)
    );

    // Result routing into the queue
    assign row_count_inc = (row_count_reg == ROW_IDX_MAX) ? row_count_reg
                                                          : row_count_reg + ROW_IDX_ONE;

    always_comb
    begin
        push_a = in_xfer && (held_reg || last_row);
        push_b = in_xfer && held_reg && last_row;
        if (held_reg)
        begin
            data_a = {gen_prev, row_count_reg, 1'b0};
        end
        else
        begin
            data_a = {gen_flush, row_count_reg, 1'b1};
        end
        data_b = {gen_flush, row_count_inc, 1'b1};
    end

    // Row window and frame bookkeeping
    always_comb
    begin
        row_above_next  = row_above_reg;
        row_middle_next = row_middle_reg;
        held_next       = held_reg;
        row_count_next  = row_count_reg;
        if (in_xfer)
        begin
            if (last_row)
            begin
                row_above_next  = '0;
                row_middle_next = '0;
                held_next       = 1'b0;
                row_count_next  = '0;
            end
            else if (!held_reg)
            begin
                row_above_next  = '0;
                row_middle_next = row_cells;
                held_next       = 1'b1;
            end
            else
            begin
                row_above_next  = row_middle_reg;
                row_middle_next = row_cells;
                row_count_next  = row_count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_above_reg  <= '0;
            row_middle_reg <= '0;
            held_reg       <= 1'b0;
            row_count_reg  <= '0;
        end
        else
        begin
            row_above_reg  <= row_above_next;
            row_middle_reg <= row_middle_next;
            held_reg       <= held_next;
            row_count_reg  <= row_count_next;
        end
    end

    llars_outq #(.DATA_W(DATA_W)) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_a    (push_a),
        .data_a    (data_a),
        .push_b    (push_b),
        .data_b    (data_b),
        .space_two (space_two),
        .level     (q_level),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign next_row   = out_data[DATA_W-1 -: MAX_WIDTH];
    assign row_index  = out_data[ROW_IDX_W:1];
    assign frame_done = out_data[0];

    // Bottom row ends the frame: window and numbering start over
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && last_row) |=> (!held_reg && (row_count_reg == '0)))
        else $error("frame state not cleared after bottom row");

    // Queue never holds more than its four entries
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (q_level <= 3'd4))
        else $error("result queue overflow");

    // A two-result transfer is only taken with room for both
    a_two_fit: assert property (@(posedge clk) disable iff (!rst_n)
        push_b |=> (q_level >= 3'd2))
        else $error("second result lost");

endmodule

// ----- hdl/llars_cell.sv -----
// ----------------------------------------------------------------------------
// llars_cell
// One cell lane: counts live neighbors in a 3x3 window and looks up the rule.
// ----------------------------------------------------------------------------
module llars_cell
    import llars_pkg::*;
(
    input  logic [2:0]        up,
    input  logic [2:0]        mid,
    input  logic [2:0]        down,
    input  logic [RULE_W-1:0] rule_word,
    output logic              next_cell
);

    logic [COUNT_W-1:0]    nbr_count;
    logic [RULE_IDX_W-1:0] rule_idx;

    // Eight neighbors, center excluded
    assign nbr_count = COUNT_W'(up[0]) + COUNT_W'(up[1]) + COUNT_W'(up[2])
                     + COUNT_W'(mid[0]) + COUNT_W'(mid[2])
                     + COUNT_W'(down[0]) + COUNT_W'(down[1]) + COUNT_W'(down[2]);

    // Survive half of the rule word sits above the birth half
    assign rule_idx = mid[1] ? (ALIVE_STRIDE + RULE_IDX_W'(nbr_count))
                             : RULE_IDX_W'(nbr_count);

    assign next_cell = rule_word[rule_idx];

endmodule

// ----- hdl/llars_gen.sv -----
// ----------------------------------------------------------------------------
// llars_gen
// One generation of a full row: a lane per cell, merged into a masked row.
// ----------------------------------------------------------------------------
module llars_gen
    import llars_pkg::*;
#(
    parameter int WIDTH = 64
)
(
    input  logic [WIDTH-1:0]  up,
    input  logic [WIDTH-1:0]  mid,
    input  logic [WIDTH-1:0]  down,
    input  logic [WIDTH-1:0]  used_mask,
    input  logic [RULE_W-1:0] rule_word,
    output logic [WIDTH-1:0]  next_row
);

    logic [WIDTH+1:0] up_ext;
    logic [WIDTH+1:0] mid_ext;
    logic [WIDTH+1:0] down_ext;
    logic [WIDTH-1:0] lane_out;

    // Dead border on both sides, unused cells forced dead
    assign up_ext   = {1'b0, up   & used_mask, 1'b0};
    assign mid_ext  = {1'b0, mid  & used_mask, 1'b0};
    assign down_ext = {1'b0, down & used_mask, 1'b0};

    for (genvar x = 0; x < WIDTH; x++) begin : g_lane
        llars_cell u_cell (
            .up        (up_ext[x+2:x]),
            .mid       (mid_ext[x+2:x]),
            .down      (down_ext[x+2:x]),
            .rule_word (rule_word),
            .next_cell (lane_out[x])
        );
    end

    // Merge lanes; cells past the grid width stay dead
    assign next_row = lane_out & used_mask;

endmodule

// ----- hdl/llars_outq.sv -----
// ----------------------------------------------------------------------------
// llars_outq
// Small result queue: up to two results in per cycle, one out on out_ready.
// ----------------------------------------------------------------------------
module llars_outq
    import llars_pkg::*;
#(
    parameter int DATA_W = 81
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_a,
    input  logic [DATA_W-1:0] data_a,
    input  logic              push_b,
    input  logic [DATA_W-1:0] data_b,
    output logic              space_two,
    output logic [2:0]        level,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    localparam int DEPTH = 4;

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [1:0]        wr_ptr_reg;
    logic [1:0]        wr_ptr_next;
    logic [1:0]        rd_ptr_reg;
    logic [1:0]        rd_ptr_next;
    logic [2:0]        count_reg;
    logic [2:0]        count_next;
    logic              pop;
    logic [1:0]        wr_ptr_b;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 3'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign space_two = (count_reg <= 3'(DEPTH - 2));
    assign level     = count_reg;
    assign wr_ptr_b  = wr_ptr_reg + 2'd1;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + 2'(push_a) + 2'(push_b);
        rd_ptr_next = rd_ptr_reg + 2'(pop);
        count_next  = count_reg + 3'(push_a) + 3'(push_b) - 3'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; the second result lands behind the first
    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            entry_reg[wr_ptr_reg] <= data_a;
        end
        if (push_b)
        begin
            entry_reg[wr_ptr_b] <= data_b;
        end
    end

endmodule
